// File: rtl/nprm_pkg.sv
// ----------------------------------------------------------------------------
// nprm_pkg: shared types and constants for the pattern rule matcher
// Holds default sizes, fixed field widths, action, compare and register codes,
// and the control bundle passed from the sequencer to the merge stage.
// ----------------------------------------------------------------------------
package nprm_pkg;

  // Default sizes
  localparam int DEF_MAX_PATTERNS = 32;
  localparam int DEF_MAX_CELLS    = 9;
  localparam int DEF_STATE_BITS   = 4;
  localparam int DEF_LANE_BITS    = 3;

  // Fixed field widths
  localparam int ACT_W      = 2;
  localparam int CMP_W      = 2;
  localparam int LIMIT_W    = 4;
  localparam int PIU_W      = 6;
  localparam int CIU_W      = 4;
  localparam int CTR_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_EVAL = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CELL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_HEAD = 2'd2;

  // Count compare codes; the fourth code places no constraint
  localparam logic [CMP_W-1:0] CMP_GT = 2'd0;
  localparam logic [CMP_W-1:0] CMP_LT = 2'd1;
  localparam logic [CMP_W-1:0] CMP_EQ = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE   = 2'd2;

  // Register reset values
  localparam logic [PIU_W-1:0] PIU_RESET = 6'd0;
  localparam logic [CIU_W-1:0] CIU_RESET = 4'd9;
  localparam logic [CTR_W-1:0] CTR_RESET = 4'd4;

  // Control from sequencer to merge stage
  typedef struct packed {
    logic clear;
    logic valid;
  } merge_ctl_t;

  // Bits needed to index n entries
  function automatic int idx_w(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Bits needed to hold the values 0 .. n
  function automatic int cnt_w(int n);
    return (n > 0) ? $clog2(n + 1) : 1;
  endfunction

endpackage

// File: rtl/neighbourhood_pattern_rule_match_core.sv
// ----------------------------------------------------------------------------
// neighbourhood_pattern_rule_match_core: rule pattern matcher, top level
// Evaluate items: P = patterns in use (saturated), L = lanes; ceil(P/L) batches
//   of L patterns are read one per cycle from the lane memories, then the result
//   is registered once the pipeline has drained and any earlier result has been
//   taken; inputs stall until then.
// Reset (synchronous, active low) clears control and loads register defaults;
//   pattern memories are not cleared and are undefined until written.
// ----------------------------------------------------------------------------
module neighbourhood_pattern_rule_match_core #(
  parameter int MAX_PATTERNS = nprm_pkg::DEF_MAX_PATTERNS,
  parameter int MAX_CELLS    = nprm_pkg::DEF_MAX_CELLS,
  parameter int STATE_BITS   = nprm_pkg::DEF_STATE_BITS,
  parameter int LANE_BITS    = nprm_pkg::DEF_LANE_BITS
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // configuration write
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [nprm_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [nprm_pkg::CFG_DATA_W-1:0]            cfg_data,
  // input items
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic [nprm_pkg::ACT_W-1:0]                 in_action,
  input  logic [MAX_CELLS*STATE_BITS-1:0]            in_neighbourhood,
  input  logic [nprm_pkg::idx_w(MAX_PATTERNS)-1:0]   in_pattern_index,
  input  logic [nprm_pkg::idx_w(MAX_CELLS)-1:0]      in_cell_index,
  input  logic [(1 << STATE_BITS)-1:0]               in_cell_mask,
  input  logic                                       in_cell_is_wildcard,
  input  logic                                       in_count_enabled,
  input  logic [STATE_BITS-1:0]                      in_count_state,
  input  logic [nprm_pkg::CMP_W-1:0]                 in_count_compare,
  input  logic [nprm_pkg::LIMIT_W-1:0]               in_count_limit,
  input  logic [STATE_BITS-1:0]                      in_result_state,
  // result items
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic [STATE_BITS-1:0]                      out_next_state,
  output logic                                       out_matched,
  output logic [nprm_pkg::idx_w(MAX_PATTERNS)-1:0]   out_matched_pattern
);
  import nprm_pkg::*;

  localparam int LANES  = 1 << LANE_BITS;
  localparam int DEPTH  = (MAX_PATTERNS + LANES - 1) / LANES;
  localparam int AW     = idx_w(DEPTH);
  localparam int PXW    = AW + LANE_BITS;
  localparam int PIW    = idx_w(MAX_PATTERNS);
  localparam int CIW    = idx_w(MAX_CELLS);
  localparam int NPW    = cnt_w(MAX_PATTERNS);
  localparam int NCW    = cnt_w(MAX_CELLS);
  localparam int NB_W   = MAX_CELLS * STATE_BITS;
  localparam int MASK_W = 1 << STATE_BITS;
  localparam int CW     = MASK_W + 1;
  localparam int HW     = 1 + STATE_BITS + CMP_W + LIMIT_W + STATE_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  // Configuration registers
  logic [PIU_W-1:0] piu_r;
  logic [CIU_W-1:0] ciu_r;
  logic [CTR_W-1:0] ctr_r;

  logic [NPW-1:0]   np_sat;
  logic [NCW-1:0]   nc_sat;
  logic [AW:0]      nbat;
  logic [NPW+LANE_BITS-1:0] nbat_sum;

  // Handshake and write decode
  logic             in_fire;
  logic             out_fire;
  logic             eval_fire;
  logic             cell_we;
  logic             head_we;
  logic [PXW-1:0]   wr_pidx;
  logic [LANE_BITS-1:0] wr_lane;
  logic [AW-1:0]    wr_addr;

  // Sequencer
  state_t           state_r, state_nxt;
  logic [AW:0]      b_r, b_nxt;
  logic [NB_W-1:0]  nb_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATE_BITS-1:0] out_state_r, out_state_nxt;
  logic                  out_matched_r, out_matched_nxt;
  logic [PIW-1:0]        out_pidx_r, out_pidx_nxt;
  logic [STATE_BITS-1:0] centre_state;

  // Read and evaluate pipeline
  logic                 rd_valid_r;
  logic [AW-1:0]        rd_batch_r;
  logic [MAX_CELLS-1:0][CW-1:0] crow_r [LANES];
  logic [HW-1:0]        hrow_r [LANES];
  logic [LANES-1:0]     lane_match;
  logic [LANES-1:0]     lane_ok;
  logic                 valid2_r;
  logic [AW-1:0]        batch2_r;
  logic [LANES-1:0]     hit2_r;
  logic [LANES-1:0][STATE_BITS-1:0] res2_r;

  merge_ctl_t           mctl;
  logic                 m_found;
  logic [STATE_BITS-1:0] m_result;
  logic [PXW-1:0]       m_pidx;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign eval_fire = in_fire && (in_action == ACT_EVAL);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piu_r <= PIU_RESET;
      ciu_r <= CIU_RESET;
      ctr_r <= CTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERNS: piu_r <= cfg_data[PIU_W-1:0];
        CFG_CELLS:    ciu_r <= cfg_data[CIU_W-1:0];
        CFG_CENTRE:   ctr_r <= cfg_data[CTR_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate counts and derive the number of batches
  assign np_sat   = (piu_r > MAX_PATTERNS) ? NPW'(MAX_PATTERNS) : NPW'(piu_r);
  assign nc_sat   = (ciu_r > MAX_CELLS) ? NCW'(MAX_CELLS) : NCW'(ciu_r);
  assign nbat_sum = (NPW+LANE_BITS)'(np_sat) + (NPW+LANE_BITS)'(LANES - 1);
  assign nbat     = (AW+1)'(nbat_sum >> LANE_BITS);

  // Split a pattern index into lane and row
  assign wr_pidx = PXW'(in_pattern_index);
  assign wr_lane = wr_pidx[LANE_BITS-1:0];
  assign wr_addr = wr_pidx[PXW-1:LANE_BITS];
  assign cell_we = in_fire && (in_action == ACT_CELL) &&
                   (in_pattern_index < MAX_PATTERNS) && (in_cell_index < MAX_CELLS);
  assign head_we = in_fire && (in_action == ACT_HEAD) &&
                   (in_pattern_index < MAX_PATTERNS);

  // Lane memories: one row per pattern, written per cell, read one row a cycle
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [MAX_CELLS-1:0][CW-1:0] cmem [DEPTH];
    logic [HW-1:0]                hmem [DEPTH];
    logic [PXW-1:0]               p_idx;

    always_ff @(posedge clk) begin
      if (cell_we && (wr_lane == LANE_BITS'(l))) begin
        cmem[wr_addr][in_cell_index] <= {in_cell_is_wildcard, in_cell_mask};
      end
      if (head_we && (wr_lane == LANE_BITS'(l))) begin
        hmem[wr_addr] <= {in_count_enabled, in_count_state, in_count_compare,
                          in_count_limit, in_result_state};
      end
    end

    always_ff @(posedge clk) begin
      crow_r[l] <= cmem[b_r[AW-1:0]];
      hrow_r[l] <= hmem[b_r[AW-1:0]];
    end

    // Drop lanes beyond the patterns in use
    assign p_idx      = {rd_batch_r, LANE_BITS'(l)};
    assign lane_ok[l] = (PXW+1)'(p_idx) < (PXW+1)'(np_sat);

    nprm_lane #(
      .MAX_CELLS  (MAX_CELLS),
      .STATE_BITS (STATE_BITS)
    ) u_lane (
      .cells       (crow_r[l]),
      .count_on    (hrow_r[l][HW-1]),
      .count_state (hrow_r[l][HW-2 -: STATE_BITS]),
      .compare     (hrow_r[l][STATE_BITS+LIMIT_W +: CMP_W]),
      .limit       (hrow_r[l][STATE_BITS +: LIMIT_W]),
      .nb          (nb_r),
      .nc          (nc_sat),
      .match       (lane_match[l])
    );

    always_ff @(posedge clk) begin
      hit2_r[l] <= lane_match[l] && lane_ok[l] && rd_valid_r;
      res2_r[l] <= hrow_r[l][STATE_BITS-1:0];
    end
  end

  // Advance pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      valid2_r   <= 1'b0;
    end else begin
      rd_valid_r <= (state_r == ST_RUN);
      valid2_r   <= rd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_batch_r <= b_r[AW-1:0];
    batch2_r   <= rd_batch_r;
    if (eval_fire) begin
      nb_r <= in_neighbourhood;
    end
  end

  assign mctl.clear = eval_fire;
  assign mctl.valid = valid2_r;

  nprm_merge #(
    .LANE_BITS  (LANE_BITS),
    .STATE_BITS (STATE_BITS),
    .AW         (AW)
  ) u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mctl),
    .hit    (hit2_r),
    .res    (res2_r),
    .batch  (batch2_r),
    .found  (m_found),
    .result (m_result),
    .pidx   (m_pidx)
  );

  // Centre cell state, zero when the centre lies outside the neighbourhood
  always_comb begin
    centre_state = '0;
    for (int i = 0; i < MAX_CELLS; i++) begin
      if (ctr_r == CTR_W'(i)) begin
        centre_state = nb_r[i*STATE_BITS +: STATE_BITS];
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt       = state_r;
    b_nxt           = b_r;
    out_valid_nxt   = out_fire ? 1'b0 : out_valid_r;
    out_state_nxt   = out_state_r;
    out_matched_nxt = out_matched_r;
    out_pidx_nxt    = out_pidx_r;
    case (state_r)
      ST_IDLE: begin
        b_nxt = '0;
        if (eval_fire) begin
          state_nxt = (nbat == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        b_nxt = b_r + (AW+1)'(1);
        if (b_nxt == nbat) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid_r && !valid2_r && (!out_valid_r || !out_stall)) begin
          state_nxt       = ST_IDLE;
          out_valid_nxt   = 1'b1;
          out_matched_nxt = m_found;
          out_state_nxt   = m_found ? m_result : centre_state;
          out_pidx_nxt    = m_found ? PIW'(m_pidx) : '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      b_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      b_r         <= b_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_state_r   <= out_state_nxt;
    out_matched_r <= out_matched_nxt;
    out_pidx_r    <= out_pidx_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_next_state      = out_state_r;
  assign out_matched         = out_matched_r;
  assign out_matched_pattern = out_pidx_r;

  // A new result appears only when the drain phase ends
  a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DRAIN))
    else $error("result loaded outside drain");

  // A matched pattern lies inside the patterns in use
  a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_matched_r) |-> ((PXW+1)'(out_pidx_r) < (PXW+1)'(np_sat)))
    else $error("matched pattern beyond patterns in use");

  // Memory reads are in flight only while an evaluation is running
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid_r || valid2_r) |-> (state_r != ST_IDLE))
    else $error("pipeline active while idle");

  // The batch counter stays below the batch count while issuing
  a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (b_r < nbat))
    else $error("batch counter overran");

endmodule

// File: rtl/nprm_lane.sv
// ----------------------------------------------------------------------------
// nprm_lane: single pattern test
// Checks one stored pattern against a neighbourhood: every active non-wildcard
// cell must allow its state, and the wildcard count must meet the header rule.
// ----------------------------------------------------------------------------
module nprm_lane #(
  parameter int MAX_CELLS  = nprm_pkg::DEF_MAX_CELLS,
  parameter int STATE_BITS = nprm_pkg::DEF_STATE_BITS
) (
  input  logic [MAX_CELLS*((1 << STATE_BITS) + 1)-1:0] cells,
  input  logic                                         count_on,
  input  logic [STATE_BITS-1:0]                        count_state,
  input  logic [nprm_pkg::CMP_W-1:0]                   compare,
  input  logic [nprm_pkg::LIMIT_W-1:0]                 limit,
  input  logic [MAX_CELLS*STATE_BITS-1:0]              nb,
  input  logic [nprm_pkg::cnt_w(MAX_CELLS)-1:0]        nc,
  output logic                                         match
);
  import nprm_pkg::*;

  localparam int MASK_W = 1 << STATE_BITS;
  localparam int CW     = MASK_W + 1;
  localparam int NCW    = cnt_w(MAX_CELLS);
  localparam int CMPW   = (NCW > LIMIT_W) ? NCW : LIMIT_W;

  logic                  cells_ok;
  logic [NCW-1:0]        cnt;
  logic [CMPW-1:0]       cnt_x;
  logic [CMPW-1:0]       lim_x;
  logic                  cnt_ok;

  // Test each active cell and count wildcard cells holding the chosen state
  always_comb begin
    logic [STATE_BITS-1:0] s;
    logic [MASK_W-1:0]     mask;
    logic                  wild;
    cells_ok = 1'b1;
    cnt      = '0;
    for (int i = 0; i < MAX_CELLS; i++) begin
      s    = nb[i*STATE_BITS +: STATE_BITS];
      mask = cells[i*CW +: MASK_W];
      wild = cells[i*CW + MASK_W];
      if (NCW'(i) < nc) begin
        if (wild) begin
          if (s == count_state) begin
            cnt = cnt + NCW'(1);
          end
        end else if (!mask[s]) begin
          cells_ok = 1'b0;
        end
      end
    end
  end

  // Apply the count rule
  assign cnt_x = CMPW'(cnt);
  assign lim_x = CMPW'(limit);

  always_comb begin
    case (compare)
      CMP_GT:  cnt_ok = cnt_x > lim_x;
      CMP_LT:  cnt_ok = cnt_x < lim_x;
      CMP_EQ:  cnt_ok = cnt_x == lim_x;
      default: cnt_ok = 1'b1;
    endcase
  end

  assign match = cells_ok && (!count_on || cnt_ok);

endmodule

// File: rtl/nprm_merge.sv
// ----------------------------------------------------------------------------
// nprm_merge: first-match merge across lanes and batches
// Picks the lowest matching lane of a batch and keeps the first hit seen since
// the last clear, with its result state and pattern index.
// ----------------------------------------------------------------------------
module nprm_merge #(
  parameter int LANE_BITS  = nprm_pkg::DEF_LANE_BITS,
  parameter int STATE_BITS = nprm_pkg::DEF_STATE_BITS,
  parameter int AW         = 2
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  nprm_pkg::merge_ctl_t                     ctl,
  input  logic [(1 << LANE_BITS)-1:0]              hit,
  input  logic [(1 << LANE_BITS)-1:0][STATE_BITS-1:0] res,
  input  logic [AW-1:0]                            batch,
  output logic                                     found,
  output logic [STATE_BITS-1:0]                    result,
  output logic [AW+LANE_BITS-1:0]                  pidx
);
  import nprm_pkg::*;

  localparam int LANES = 1 << LANE_BITS;

  logic                     any_hit;
  logic [LANE_BITS-1:0]     sel;
  logic                     found_r;
  logic [STATE_BITS-1:0]    result_r;
  logic [AW+LANE_BITS-1:0]  pidx_r;
  logic                     take;

  // Pick the lowest lane that hit
  always_comb begin
    any_hit = |hit;
    sel     = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel = LANE_BITS'(i);
      end
    end
  end

  assign take = ctl.valid && !found_r && any_hit;

  // Hold the first hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= res[sel];
      pidx_r   <= {batch, sel};
    end
  end

  assign found  = found_r;
  assign result = result_r;
  assign pidx   = pidx_r;

endmodule
